FILE: hdl/gha_pkg.sv
// Package for the generational handle allocator.
// Holds the command, status and controller state codes and the fixed field widths.
// No dependencies.
package gha_pkg;

  // Widths of the handle fields at the block boundary.
  localparam int unsigned ID_W  = 32;
  localparam int unsigned IDX_W = 8;

  // First identifier handed out after reset and after a wrap.
  localparam logic [ID_W-1:0] NEXT_ID_FIRST = 32'd1;

  // Command codes. The code that is not listed behaves as a check.
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

endpackage

FILE: hdl/gha_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot tag table and the free-list links. No dependencies.
module gha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: hdl/generational_handle_allocator_top.sv
// Top level of the generational handle allocator: controller, free-list head and counters.
// Depends on gha_pkg and two instances of gha_ram (slot tags and free-list links).
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------
//   input   | in_valid, in_stall | in_cmd, in_handle_id, in_handle_index
//   result  | out_valid,out_stall| out_status, out_id, out_index
//
// Every command first reads the tag and link memories at the slot in question,
// then checks, writes back and loads the result register.
// The next command is taken once the write-back is done, so a command always
// reads what the one before it wrote. A stalled result register holds the
// write-back cycle until it frees up. Reset is synchronous and needs no clearing
// pass: a fill mark tracks which slots have never been written, and those read
// as empty with the link to the following slot.
module generational_handle_allocator_top
  import gha_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input channel.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [ID_W-1:0]  in_handle_id,
  input  logic [IDX_W-1:0] in_handle_index,
  // Result channel.
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [ID_W-1:0]  out_id,
  output logic [IDX_W-1:0] out_index
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  // Control and counter registers.
  fsm_t             state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [ID_W-1:0]  id_ctr_r, id_ctr_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Captured command.
  logic [1:0]       cmd_r, cmd_nxt;
  logic [ID_W-1:0]  hid_r, hid_nxt;
  logic [IDX_W-1:0] hidx_r, hidx_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             idx_ok_r, idx_ok_nxt;

  // Result register.
  logic [1:0]       status_r, status_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic [IDX_W-1:0] oidx_r, oidx_nxt;

  // Memory ports.
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [ID_W-1:0]  tag_rdata;
  logic [AW-1:0]    link_rdata;
  logic             tag_we, link_we;
  logic [ID_W-1:0]  tag_wdata;
  logic [AW-1:0]    link_wdata;

  // Decode helpers.
  logic             accept;
  logic             fire;
  logic             fresh;
  logic [ID_W-1:0]  tag_q;
  logic [AW-1:0]    link_q;
  logic             handle_ok;
  logic [ID_W-1:0]  id_inc;

  gha_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (addr_r),
    .wr_data (tag_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (tag_rdata)
  );

  gha_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (addr_r),
    .wr_data (link_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (link_rdata)
  );

  // Handshake.
  assign in_stall = (state_r != FSM_IDLE);
  assign accept   = in_valid && (state_r == FSM_IDLE);
  assign fire     = (state_r == FSM_EXEC) && (!out_valid_r || !out_stall);

  // Read both memories at the slot the command touches.
  assign rd_en   = accept;
  assign rd_addr = (in_cmd == CMD_ALLOC) ? head_r : AW'(in_handle_index);

  // Slots at or above the fill mark have never been written.
  assign fresh  = (CW'(addr_r) >= fill_r);
  assign tag_q  = fresh ? '0 : tag_rdata;
  assign link_q = fresh ? ((addr_r == LAST_SLOT) ? '0 : addr_r + AW'(1)) : link_rdata;

  assign handle_ok = idx_ok_r && (hid_r != '0) && (tag_q == hid_r);
  assign id_inc    = id_ctr_r + ID_W'(1);

  // Next state, write-back and result.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    id_ctr_nxt    = id_ctr_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_nxt       = cmd_r;
    hid_nxt       = hid_r;
    hidx_nxt      = hidx_r;
    addr_nxt      = addr_r;
    idx_ok_nxt    = idx_ok_r;
    status_nxt    = status_r;
    oid_nxt       = oid_r;
    oidx_nxt      = oidx_r;
    tag_we        = 1'b0;
    link_we       = 1'b0;
    tag_wdata     = '0;
    link_wdata    = head_r;

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt  = FSM_EXEC;
          cmd_nxt    = in_cmd;
          hid_nxt    = in_handle_id;
          hidx_nxt   = in_handle_index;
          addr_nxt   = rd_addr;
          idx_ok_nxt = (32'(in_handle_index) < 32'(CAPACITY));
        end
      end
      FSM_EXEC: begin
        if (fire) begin
          state_nxt     = FSM_IDLE;
          out_valid_nxt = 1'b1;
          case (cmd_r)
            CMD_ALLOC: begin
              if (count_r == '0) begin
                status_nxt = ST_FULL;
                oid_nxt    = '0;
                oidx_nxt   = '0;
              end else begin
                status_nxt = ST_OK;
                oid_nxt    = id_ctr_r;
                oidx_nxt   = IDX_W'(addr_r);
                tag_we     = 1'b1;
                tag_wdata  = id_ctr_r;
                head_nxt   = link_q;
                count_nxt  = count_r - CW'(1);
                id_ctr_nxt = (id_inc == '0) ? NEXT_ID_FIRST : id_inc;
                if (fresh) begin
                  fill_nxt = fill_r + CW'(1);
                end
              end
            end
            CMD_RELEASE: begin
              oidx_nxt = hidx_r;
              if (handle_ok) begin
                status_nxt = ST_OK;
                oid_nxt    = hid_r;
                tag_we     = 1'b1;
                link_we    = 1'b1;
                head_nxt   = addr_r;
                count_nxt  = count_r + CW'(1);
              end else begin
                status_nxt = ST_STALE;
                oid_nxt    = '0;
              end
            end
            default: begin
              // Check, and the unused code, which behaves as a check.
              oidx_nxt = hidx_r;
              if (handle_ok) begin
                status_nxt = ST_OK;
                oid_nxt    = hid_r;
              end else begin
                status_nxt = ST_STALE;
                oid_nxt    = '0;
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      head_r      <= '0;
      count_r     <= FULL_CNT;
      fill_r      <= '0;
      id_ctr_r    <= NEXT_ID_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      id_ctr_r    <= id_ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    hid_r    <= hid_nxt;
    hidx_r   <= hidx_nxt;
    addr_r   <= addr_nxt;
    idx_ok_r <= idx_ok_nxt;
    status_r <= status_nxt;
    oid_r    <= oid_nxt;
    oidx_r   <= oidx_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_id     = oid_r;
  assign out_index  = oidx_r;

  // The free count and the fill mark never pass the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= FULL_CNT) && (fill_r <= FULL_CNT))
    else $error("free count or fill mark beyond capacity");

  // A new result only appears after a write-back cycle.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == FSM_EXEC))
    else $error("result appeared without a write-back cycle");

  // A full or stale result never carries an identifier.
  a_error_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FULL || status_r == ST_STALE)) |-> (oid_r == '0))
    else $error("error result carries an identifier");

  // A successful allocation always hands out a non-zero identifier.
  a_alloc_id: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r == CMD_ALLOC && count_r != '0) |=> (oid_r != '0))
    else $error("allocation produced a zero identifier");

endmodule
